>>> rtl/wlp_pkg.sv
// shared constants, opcodes, state encoding and word types for the lottery picker
package wlp_pkg;

  localparam int MAX_ENTRIES = 8;
  localparam int WEIGHT_BITS = 24;
  localparam int IDX_W       = 3;
  localparam int CNT_W       = 4;
  localparam int SUM_W       = WEIGHT_BITS + $clog2(MAX_ENTRIES);
  localparam int GEN_W       = 32;
  localparam int DIV_CNT_W   = $clog2(GEN_W);

  localparam logic [GEN_W-1:0]     FALLBACK_SEED = 32'hA5A5_A5A5;
  localparam logic [GEN_W-1:0]     LCG_MUL       = 32'd1664525;
  localparam logic [GEN_W-1:0]     LCG_ADD       = 32'd1013904223;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST      = DIV_CNT_W'(GEN_W - 1);

  typedef enum logic [1:0] {
    OP_PICK   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_RESEED = 2'd2,
    OP_NOP    = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_CHECK,
    ST_ADV,
    ST_DIV,
    ST_WALK
  } state_t;

  typedef struct packed {
    logic [1:0]             opcode;
    logic [IDX_W-1:0]       entry_index;
    logic [WEIGHT_BITS-1:0] weight;
    logic [GEN_W-1:0]       seed;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0] picked_index;
    logic             pick_made;
  } out_word_t;

endpackage

>>> rtl/weighted_lottery_picker_core.sv
// weighted lottery picker: weight table in ram, lcg generator, serial modulo and weight walk
//
// usage:
//   a command word on item is taken at a rising edge with start high and busy low.
//   opcodes: pick an entry, write one weight, reseed the generator, no operation.
//   every command gives one result word on result, shown for one cycle with done high.
//   write, reseed and no-op: done comes in the cycle after acceptance, busy stays low,
//   so such commands can follow one another every cycle.
//   a pick runs a summing scan of the active entries in the ram, one check step, one
//   generator step, a restoring modulo of the 32-bit generator word by the total, and a
//   walk of the ram; busy is high throughout and done follows. an empty lottery (no
//   active entry or a zero total) ends after the check.
//   the ram read port and the one-bit-per-cycle modulo set the pick time.
//   entry_count is written on the cfg channel; cfg_ready is low while busy.
//   reset clears the table through per-entry valid bits, loads the fallback seed and
//   sets entry_count to zero; nothing needs to sweep the ram.
//   the receiver cannot stall: each result word is valid only in its done cycle.
module weighted_lottery_picker_core import wlp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  in_word_t         item,
  output logic             done,
  output out_word_t        result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data
);

  state_t                  state, state_next;
  logic [CNT_W-1:0]        entry_count;
  logic [CNT_W-1:0]        n_act;
  logic [CNT_W-1:0]        issue_cnt;
  logic [MAX_ENTRIES-1:0]  wvld;
  logic [GEN_W-1:0]        gen, gen_adv, dividend;
  logic [SUM_W-1:0]        total, rem, running, run_sum, acc_sum, rem_next;
  logic [SUM_W:0]          trial;
  logic [DIV_CNT_W-1:0]    bit_cnt;
  logic                    pipe_vld, rd_vld, found;
  logic [IDX_W-1:0]        pipe_idx, picked, rd_addr;
  logic [WEIGHT_BITS-1:0]  ram_q, rd_w;
  logic                    accept, issue, scan_done, ram_we;

  wlp_ram #(
    .WIDTH(WEIGHT_BITS),
    .DEPTH(MAX_ENTRIES)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(item.entry_index),
    .wdata(item.weight),
    .raddr(rd_addr),
    .rdata(ram_q)
  );

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = !busy;
  assign accept    = start && !busy;

  always_comb begin
    n_act     = (entry_count > CNT_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES) : entry_count;
    issue     = ((state == ST_SUM) || (state == ST_WALK)) && (issue_cnt < n_act);
    scan_done = !(issue_cnt < n_act) && !pipe_vld;
    rd_addr   = issue_cnt[IDX_W-1:0];
    // entries never written since reset read as zero
    rd_w      = rd_vld ? ram_q : '0;
    acc_sum   = total + SUM_W'(rd_w);
    run_sum   = running + SUM_W'(rd_w);
    trial     = {rem, dividend[GEN_W-1]};
    rem_next  = (trial >= {1'b0, total}) ? SUM_W'(trial - {1'b0, total}) : trial[SUM_W-1:0];
    gen_adv   = GEN_W'(gen * LCG_MUL) + LCG_ADD;
    ram_we    = accept && (item.opcode == OP_WRITE) &&
                ({1'b0, item.entry_index} < CNT_W'(MAX_ENTRIES));

    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (item.opcode == OP_PICK)) begin
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        if (scan_done) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if ((n_act == '0) || (total == '0)) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_ADV;
        end
      end
      ST_ADV: begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (bit_cnt == DIV_LAST) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (scan_done) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      wvld        <= '0;
      gen         <= FALLBACK_SEED;
      entry_count <= '0;
      done        <= 1'b0;
      pipe_vld    <= 1'b0;
    end else begin
      state    <= state_next;
      pipe_vld <= issue;
      done     <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        entry_count <= cfg_data;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (item.opcode != OP_PICK) begin
              done <= 1'b1;
            end
            if (ram_we) begin
              wvld[item.entry_index] <= 1'b1;
            end
            if (item.opcode == OP_RESEED) begin
              gen <= (item.seed == '0) ? FALLBACK_SEED : item.seed;
            end
          end
        end
        ST_CHECK: begin
          if ((n_act == '0) || (total == '0)) begin
            done <= 1'b1;
          end
        end
        ST_ADV: begin
          gen <= gen_adv;
        end
        ST_WALK: begin
          if (scan_done) begin
            done <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    rd_vld   <= wvld[rd_addr];
    pipe_idx <= rd_addr;
    if (issue) begin
      issue_cnt <= issue_cnt + 1'b1;
    end
    case (state)
      ST_IDLE: begin
        issue_cnt <= '0;
        total     <= '0;
        if (accept) begin
          result <= '0;
        end
      end
      ST_SUM: begin
        if (pipe_vld) begin
          total <= acc_sum;
        end
      end
      ST_CHECK: begin
        issue_cnt <= '0;
        running   <= '0;
        found     <= 1'b0;
        picked    <= IDX_W'(n_act - 1'b1);
        result    <= '0;
      end
      ST_ADV: begin
        dividend <= gen_adv;
        rem      <= '0;
        bit_cnt  <= '0;
      end
      ST_DIV: begin
        rem      <= rem_next;
        dividend <= {dividend[GEN_W-2:0], 1'b0};
        bit_cnt  <= bit_cnt + 1'b1;
      end
      ST_WALK: begin
        if (pipe_vld) begin
          running <= run_sum;
          // first entry whose running sum passes the ticket wins
          if (!found && (rem < run_sum)) begin
            found  <= 1'b1;
            picked <= pipe_idx;
          end
        end
        if (scan_done) begin
          result.picked_index <= picked;
          result.pick_made    <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  a_pick_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && (item.opcode == OP_PICK)) |=> busy)
    else $error("pick accepted but block not busy");

  a_other_done_next: assert property (@(posedge clk) disable iff (rst)
    (accept && (item.opcode != OP_PICK)) |=> (done && !result.pick_made))
    else $error("non-pick word did not complete in one cycle");

  a_pick_in_range: assert property (@(posedge clk) disable iff (rst)
    (done && result.pick_made) |-> ({1'b0, result.picked_index} < n_act))
    else $error("picked entry outside active range");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (total != '0))
    else $error("modulo started with zero total");

endmodule

>>> rtl/wlp_ram.sv
// generic single write port, single read port ram with registered read data
module wlp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> tb/sv/tb_weighted_lottery_picker_core.sv
// self-checking testbench for the weighted lottery picker core
module tb_weighted_lottery_picker_core;
  import wlp_pkg::*;

  localparam int IDLE_LIMIT  = 1500;
  localparam int END_CYCLES  = 64;
  localparam int PHASE_ITEMS = 110;

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  in_word_t         item;
  logic             done;
  out_word_t        result;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data;

  // predicted block state
  logic [WEIGHT_BITS-1:0] mdl_weight [MAX_ENTRIES];
  logic [GEN_W-1:0]       mdl_lcg;
  logic [CNT_W-1:0]       mdl_count;

  out_word_t pick_expect_q[$];

  int errors;
  int n_items;
  int n_draws;
  int n_empty;
  int n_settings;
  int idle_cycles;

  weighted_lottery_picker_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // expected word for one command; updates the predicted state
  function automatic out_word_t lottery_predict(in_word_t w);
    out_word_t       r;
    int              n;
    int              i;
    longint unsigned total;
    longint unsigned running;
    longint unsigned ticket;
    logic            found;
    r = '0;
    case (opcode_t'(w.opcode))
      OP_PICK: begin
        n = (mdl_count > MAX_ENTRIES) ? MAX_ENTRIES : int'(mdl_count);
        total = 0;
        for (i = 0; i < n; i++) total += mdl_weight[i];
        if (n != 0 && total != 0) begin
          mdl_lcg = mdl_lcg * LCG_MUL + LCG_ADD;
          ticket = longint'(mdl_lcg) % total;
          r.picked_index = IDX_W'(n - 1);
          running = 0;
          found = 1'b0;
          for (i = 0; i < n; i++) begin
            running += mdl_weight[i];
            if (!found && ticket < running) begin
              r.picked_index = IDX_W'(i);
              found = 1'b1;
            end
          end
          r.pick_made = 1'b1;
        end
      end
      OP_WRITE: mdl_weight[w.entry_index] = w.weight;
      OP_RESEED: mdl_lcg = (w.seed == '0) ? FALLBACK_SEED : w.seed;
      default: ;
    endcase
    return r;
  endfunction

  function automatic in_word_t mk_word(opcode_t op, int idx, logic [WEIGHT_BITS-1:0] wt,
                                       logic [GEN_W-1:0] sd);
    in_word_t w;
    w.opcode      = op;
    w.entry_index = IDX_W'(idx);
    w.weight      = wt;
    w.seed        = sd;
    return w;
  endfunction

  function automatic logic [WEIGHT_BITS-1:0] rand_weight();
    logic [WEIGHT_BITS-1:0] wt;
    int k;
    case ($urandom_range(0, 5))
      0: wt = '0;
      1: wt = '1;
      2: wt = WEIGHT_BITS'($urandom_range(1, 15));
      3: begin
        k = $urandom_range(1, WEIGHT_BITS);
        wt = WEIGHT_BITS'($urandom) & WEIGHT_BITS'((32'd1 << k) - 1);
      end
      default: wt = WEIGHT_BITS'($urandom);
    endcase
    return wt;
  endfunction

  function automatic in_word_t rand_word();
    in_word_t w;
    int sel;
    w.opcode      = 2'($urandom);
    w.entry_index = IDX_W'($urandom);
    w.weight      = rand_weight();
    w.seed        = $urandom;
    // half picks so the draw logic gets exercised, with writes to keep the table moving
    sel = $urandom_range(0, 99);
    if (sel < 50) w.opcode = OP_PICK;
    else if (sel < 80) w.opcode = OP_WRITE;
    else if (sel < 90) w.opcode = OP_RESEED;
    else w.opcode = OP_NOP;
    if (w.opcode == OP_RESEED && $urandom_range(0, 7) == 0) w.seed = '0;
    return w;
  endfunction

  // send one command word after gap idle cycles and record its expected result
  task automatic send_cmd(in_word_t w, int gap);
    out_word_t e;
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    item  <= w;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    e = lottery_predict(w);
    pick_expect_q.push_back(e);
    n_items++;
    if (e.pick_made) n_draws++;
    else if (opcode_t'(w.opcode) == OP_PICK) n_empty++;
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pick_expect_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_entry_count(logic [CNT_W-1:0] v);
    wait_results_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    mdl_count = v;
    n_settings++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin
    out_word_t e;
    if (!rst && done) begin
      if (pick_expect_q.size() == 0) begin
        $display("%0t: unexpected result word picked_index=%0d pick_made=%0d", $time,
                 result.picked_index, result.pick_made);
        errors++;
      end else begin
        e = pick_expect_q.pop_front();
        if (result.picked_index !== e.picked_index) begin
          $display("%0t: picked_index expected %0d actual %0d", $time,
                   e.picked_index, result.picked_index);
          errors++;
        end
        if (result.pick_made !== e.pick_made) begin
          $display("%0t: pick_made expected %0d actual %0d", $time,
                   e.pick_made, result.pick_made);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: watchdog expired with %0d results outstanding", $time,
                 pick_expect_q.size());
        $display("tb_weighted_lottery_picker_core: errors");
        $finish;
      end
    end
  end

  task automatic test_after_reset();
    send_cmd(mk_word(OP_PICK, 0, '0, '0), 0);
    send_cmd(mk_word(OP_WRITE, 0, '1, '0), 0);
    send_cmd(mk_word(OP_WRITE, 7, '1, '1), 0);
    // nonzero weights but no active entries
    send_cmd(mk_word(OP_PICK, 7, '1, '1), 1);
  endtask

  task automatic test_corner_cases();
    write_entry_count(CNT_W'(MAX_ENTRIES));
    send_cmd(mk_word(OP_PICK, 0, '0, '0), 0);
    send_cmd(mk_word(OP_RESEED, 0, '0, '0), 0);
    send_cmd(mk_word(OP_PICK, 0, '0, '0), 0);
    send_cmd(mk_word(OP_RESEED, 5, 24'h5A5A5A, '1), 0);
    send_cmd(mk_word(OP_PICK, 0, '0, '0), 2);
    send_cmd(mk_word(OP_NOP, 7, '1, '1), 0);
    // clear the table so the active sum is zero
    send_cmd(mk_word(OP_WRITE, 0, '0, '0), 0);
    send_cmd(mk_word(OP_WRITE, 7, '0, '0), 0);
    send_cmd(mk_word(OP_PICK, 0, '0, '0), 0);
    send_cmd(mk_word(OP_WRITE, 3, 24'd1, '0), 0);
    send_cmd(mk_word(OP_PICK, 0, '0, '0), 0);
    write_entry_count('1);
    send_cmd(mk_word(OP_PICK, 0, '0, '0), 3);
    write_entry_count(CNT_W'(1));
    send_cmd(mk_word(OP_PICK, 0, '0, '0), 0);
    send_cmd(mk_word(OP_WRITE, 0, 24'd1, '0), 0);
    send_cmd(mk_word(OP_PICK, 0, '0, '0), 0);
    write_entry_count(CNT_W'(4));
    send_cmd(mk_word(OP_WRITE, 1, '1, '0), 0);
    send_cmd(mk_word(OP_PICK, 0, '0, '0), 0);
    send_cmd(mk_word(OP_WRITE, 2, 24'h800000, 32'h8000_0000), 0);
    send_cmd(mk_word(OP_PICK, 2, '0, '0), 0);
  endtask

  task automatic test_random_phases();
    logic [CNT_W-1:0] settings [12];
    int p;
    int i;
    logic burst;
    settings = '{4'd8, 4'd0, 4'd1, 4'd15, 4'd3, 4'd8, 4'd9, 4'd2, 4'd5, 4'd7, 4'd6, 4'd8};
    for (p = 0; p < 12; p++) begin
      write_entry_count((p >= 10) ? CNT_W'($urandom) : settings[p]);
      burst = 1'b0;
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 20 == 0) burst = ($urandom_range(0, 2) == 0);
        // hold off until every outstanding word is back
        if (i == PHASE_ITEMS / 2) wait_results_drained();
        send_cmd(rand_word(), burst ? 0 : $urandom_range(0, 7));
      end
    end
  endtask

  initial begin
    int k;
    rst       = 1'b1;
    start     = 1'b0;
    item      = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    errors     = 0;
    n_items    = 0;
    n_draws    = 0;
    n_empty    = 0;
    n_settings = 0;
    idle_cycles = 0;
    for (k = 0; k < MAX_ENTRIES; k++) mdl_weight[k] = '0;
    mdl_lcg   = FALLBACK_SEED;
    mdl_count = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_after_reset();
    test_corner_cases();
    test_random_phases();

    wait_results_drained();
    repeat (END_CYCLES) @(posedge clk);
    $display("run covered %0d commands over %0d entry_count settings", n_items, n_settings);
    $display("weighted draws %0d, empty-lottery picks %0d", n_draws, n_empty);
    if (errors == 0) begin
      $display("tb_weighted_lottery_picker_core: clean");
    end else begin
      $display("tb_weighted_lottery_picker_core: errors");
    end
    $finish;
  end

endmodule
